// ----- rtl/ame_pkg.sv -----
// ----------------------------------------------------------------------------
// ame_pkg: shared definitions for the affine matrix engine
// Request codes, the sequencer state encoding and the default fixed-point format.
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        REQ_IDENT  = 3'd0,
        REQ_LOAD   = 3'd1,
        REQ_CONCAT = 3'd2,
        REQ_TRANS  = 3'd3,
        REQ_POINT  = 3'd4,
        REQ_RECT   = 3'd5,
        REQ_INVERT = 3'd6
    } req_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DET  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

endpackage

// ----- rtl/affine_matrix_engine_16_16.sv -----
// ----------------------------------------------------------------------------
// affine_matrix_engine_16_16: 2D affine matrix keeper and transformer
// One shared 32x32 multiplier and a radix-2 divider run under a sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_stall  | req_type, in_xx..in_oy, pt_x1..pt_y2
//  out     | out_valid / out_stall| res_x, res_y, box_*, singular
//
//  Identity, load, unknown: straight to completion. Point, translate, concat,
//  rect: P row products (2 for point/translate, 6 concat, 8 rect). Invert:
//  determinant; nonsingular: 4 divides (divider does one bit a cycle), P=2.
//  Reset gives the identity matrix. in_stall is high while a request is in
//  work; a stalled result holds in the output register and the next request
//  may be taken meanwhile, but it completes only once the output is free.
module affine_matrix_engine_16_16 #(
    parameter int FRAC_BITS = ame_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] in_xx,
    input  logic signed [31:0] in_yx,
    input  logic signed [31:0] in_xy,
    input  logic signed [31:0] in_yy,
    input  logic signed [31:0] in_ox,
    input  logic signed [31:0] in_oy,
    input  logic signed [31:0] pt_x1,
    input  logic signed [31:0] pt_y1,
    input  logic signed [31:0] pt_x2,
    input  logic signed [31:0] pt_y2,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] box_x_min,
    output logic signed [31:0] box_y_min,
    output logic signed [31:0] box_x_max,
    output logic signed [31:0] box_y_max,
    output logic               singular
);

    localparam int DIV_STEPS = 2 * FRAC_BITS + 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [31:0] ONE     = 32'd1 << FRAC_BITS;
    localparam logic [34:0] Q_CAP   = 35'd1 << 33;
    localparam logic [33:0] Q_NMAX  = 34'h080000000;
    localparam logic [33:0] Q_PMAX  = 34'h07FFFFFFF;

    ame_pkg::state_t state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;

    logic [31:0] xx_reg, xx_next, yx_reg, yx_next, xy_reg, xy_next, yy_reg, yy_next;
    logic [31:0] ox_reg, ox_next, oy_reg, oy_next;

    // latched request
    logic [2:0]  req_reg, req_next;
    logic [31:0] mxx_reg, mxx_next, myx_reg, myx_next, mxy_reg, mxy_next;
    logic [31:0] myy_reg, myy_next, mox_reg, mox_next, moy_reg, moy_next;
    logic [31:0] x1_reg, x1_next, y1_reg, y1_next, x2_reg, x2_next, y2_reg, y2_next;

    logic signed [63:0] prod_reg, prod_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] t_reg [0:5];
    logic [31:0] t_next [0:5];
    logic [31:0] bxn_reg, bxn_next, byn_reg, byn_next, bxx_reg, bxx_next, byx_reg, byx_next;
    logic        sing_reg, sing_next;

    logic [63:0]          det_reg, det_next, dvs_reg, dvs_next, rem_reg, rem_next;
    logic [DIV_STEPS-1:0] dvd_reg, dvd_next;
    logic [33:0]          quo_reg, quo_next;
    logic                 neg_reg, neg_next;

    logic [31:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [31:0] oxn_reg, oxn_next, oyn_reg, oyn_next, oxx_reg, oxx_next, oyx_reg, oyx_next;
    logic        osing_reg, osing_next;

    // datapath helpers
    logic signed [31:0] mul_a, mul_b;
    logic [31:0] vec_u, vec_v, fx, off, sum, val;
    logic [3:0]  p_i, pa;
    logic [4:0]  pd, nprod;
    logic        s_i;
    logic [64:0] r65;
    logic        ge;
    logic [63:0] r_new;
    logic [34:0] q_t;
    logic [33:0] q_c;
    logic [31:0] q_sat;
    logic [1:0]  li;
    logic [31:0] ln_v, ln_mag;
    logic        ln_neg;

    assign in_stall  = (state_reg != ame_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_x     = rx_reg;
    assign res_y     = ry_reg;
    assign box_x_min = oxn_reg;
    assign box_y_min = oyn_reg;
    assign box_x_max = oxx_reg;
    assign box_y_max = oyx_reg;
    assign singular  = osing_reg;

    assign fx = prod_reg[FRAC_BITS+31:FRAC_BITS];

    always_comb
    begin
        case (req_reg)
            ame_pkg::REQ_CONCAT: nprod = 5'd12;
            ame_pkg::REQ_RECT:   nprod = 5'd16;
            default:             nprod = 5'd4;
        endcase
    end

    // issue side: product cnt_reg is row p_i[0] times vector element s_i
    assign p_i = cnt_reg[4:1];
    assign s_i = cnt_reg[0];

    always_comb
    begin
        case (req_reg)
            ame_pkg::REQ_CONCAT:
            begin
                case (p_i[2:1])
                    2'd0:    begin vec_u = mxx_reg; vec_v = myx_reg; end
                    2'd1:    begin vec_u = mxy_reg; vec_v = myy_reg; end
                    default: begin vec_u = mox_reg; vec_v = moy_reg; end
                endcase
            end
            ame_pkg::REQ_RECT:
            begin
                case (p_i[2:1])
                    2'd0:    begin vec_u = x1_reg; vec_v = y1_reg; end
                    2'd1:    begin vec_u = x2_reg; vec_v = y1_reg; end
                    2'd2:    begin vec_u = x2_reg; vec_v = y2_reg; end
                    default: begin vec_u = x1_reg; vec_v = y2_reg; end
                endcase
            end
            ame_pkg::REQ_INVERT:
            begin
                vec_u = ox_reg;
                vec_v = oy_reg;
            end
            default:
            begin
                vec_u = x1_reg;
                vec_v = y1_reg;
            end
        endcase

        if (state_reg == ame_pkg::S_DET)
        begin
            mul_a = cnt_reg[0] ? yx_reg : xx_reg;
            mul_b = cnt_reg[0] ? xy_reg : yy_reg;
        end
        else
        begin
            if (s_i)
                mul_a = p_i[0] ? yy_reg : xy_reg;
            else
                mul_a = p_i[0] ? yx_reg : xx_reg;
            mul_b = s_i ? vec_v : vec_u;
        end
    end

    // accumulate side, handling the product registered from the previous issue
    assign pd  = cnt_reg - 5'd1;
    assign pa  = pd[4:1];
    assign off = pa[0] ? oy_reg : ox_reg;
    assign sum = acc_reg + fx;
    assign val = (req_reg == ame_pkg::REQ_INVERT) ? (32'd0 - sum) : sum;

    // one restoring divide step
    assign r65   = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign ge    = (r65 >= {1'b0, dvs_reg});
    assign r_new = ge ? 64'(r65 - {1'b0, dvs_reg}) : r65[63:0];
    assign q_t   = {quo_reg, ge};
    assign q_c   = (q_t > Q_CAP) ? Q_CAP[33:0] : q_t[33:0];

    always_comb
    begin
        if (neg_reg)
            q_sat = (q_c > Q_NMAX) ? 32'h80000000 : (32'd0 - q_c[31:0]);
        else
            q_sat = (q_c > Q_PMAX) ? 32'h7FFFFFFF : q_c[31:0];
    end

    // numerators in order: yy, xx, -xy, -yx
    assign li = (state_reg == ame_pkg::S_DIV) ? (idx_reg + 2'd1) : 2'd0;

    always_comb
    begin
        case (li)
            2'd0:    begin ln_v = yy_reg; ln_neg = yy_reg[31]; end
            2'd1:    begin ln_v = xx_reg; ln_neg = xx_reg[31]; end
            2'd2:    begin ln_v = xy_reg; ln_neg = !xy_reg[31] && (xy_reg != 32'd0); end
            default: begin ln_v = yx_reg; ln_neg = !yx_reg[31] && (yx_reg != 32'd0); end
        endcase
        ln_mag = ln_v[31] ? (32'd0 - ln_v) : ln_v;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        xx_next = xx_reg; yx_next = yx_reg; xy_next = xy_reg; yy_next = yy_reg;
        ox_next = ox_reg; oy_next = oy_reg;
        req_next = req_reg;
        mxx_next = mxx_reg; myx_next = myx_reg; mxy_next = mxy_reg;
        myy_next = myy_reg; mox_next = mox_reg; moy_next = moy_reg;
        x1_next = x1_reg; y1_next = y1_reg; x2_next = x2_reg; y2_next = y2_reg;
        prod_next = mul_a * mul_b;
        acc_next  = acc_reg;
        for (int i = 0; i < 6; i++)
            t_next[i] = t_reg[i];
        bxn_next = bxn_reg; byn_next = byn_reg; bxx_next = bxx_reg; byx_next = byx_reg;
        sing_next = sing_reg;
        det_next = det_reg; dvs_next = dvs_reg; rem_next = rem_reg;
        dvd_next = dvd_reg; quo_next = quo_reg; neg_next = neg_reg;
        rx_next = rx_reg; ry_next = ry_reg;
        oxn_next = oxn_reg; oyn_next = oyn_reg; oxx_next = oxx_reg; oyx_next = oyx_reg;
        osing_next = osing_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ame_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_type;
                    mxx_next = in_xx; myx_next = in_yx; mxy_next = in_xy;
                    myy_next = in_yy; mox_next = in_ox; moy_next = in_oy;
                    x1_next = pt_x1; y1_next = pt_y1; x2_next = pt_x2; y2_next = pt_y2;
                    sing_next = 1'b0;
                    cnt_next  = 5'd0;
                    case (req_type)
                        ame_pkg::REQ_CONCAT, ame_pkg::REQ_TRANS,
                        ame_pkg::REQ_POINT, ame_pkg::REQ_RECT:
                            state_next = ame_pkg::S_MUL;
                        ame_pkg::REQ_INVERT:
                            state_next = ame_pkg::S_DET;
                        default:
                            state_next = ame_pkg::S_DONE;
                    endcase
                end
            end

            ame_pkg::S_MUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg != 5'd0)
                begin
                    if (!pd[0])
                    begin
                        if ((req_reg == ame_pkg::REQ_INVERT) ||
                            ((req_reg == ame_pkg::REQ_CONCAT) && (pa < 4'd4)))
                            acc_next = fx;
                        else
                            acc_next = fx + off;
                    end
                    else if (req_reg == ame_pkg::REQ_RECT)
                    begin
                        if (!pa[0])
                        begin
                            if ((pa[2:1] == 2'd0) || ($signed(val) < $signed(bxn_reg)))
                                bxn_next = val;
                            if ((pa[2:1] == 2'd0) || ($signed(val) > $signed(bxx_reg)))
                                bxx_next = val;
                        end
                        else
                        begin
                            if ((pa[2:1] == 2'd0) || ($signed(val) < $signed(byn_reg)))
                                byn_next = val;
                            if ((pa[2:1] == 2'd0) || ($signed(val) > $signed(byx_reg)))
                                byx_next = val;
                        end
                    end
                    else if (pa < 4'd6)
                    begin
                        t_next[pa[2:0]] = val;
                    end
                end
                if (cnt_reg == nprod)
                    state_next = ame_pkg::S_DONE;
            end

            ame_pkg::S_DET:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0: ;
                    5'd1: det_next = prod_reg;
                    5'd2: det_next = det_reg - prod_reg;
                    default:
                    begin
                        if (det_reg == 64'd0)
                        begin
                            sing_next  = 1'b1;
                            state_next = ame_pkg::S_DONE;
                        end
                        else
                        begin
                            dvs_next  = det_reg[63] ? (64'd0 - det_reg) : det_reg;
                            idx_next  = 2'd0;
                            step_next = '0;
                            rem_next  = 64'd0;
                            quo_next  = 34'd0;
                            dvd_next  = {ln_mag, {(2 * FRAC_BITS){1'b0}}};
                            neg_next  = ln_neg ^ det_reg[63];
                            state_next = ame_pkg::S_DIV;
                        end
                    end
                endcase
            end

            ame_pkg::S_DIV:
            begin
                rem_next  = r_new;
                quo_next  = q_c;
                dvd_next  = dvd_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    t_next[{1'b0, idx_reg}] = q_sat;
                    if (idx_reg == 2'd3)
                    begin
                        // quotients come out as xx, yy, xy, yx
                        xx_next = t_reg[0];
                        yy_next = t_reg[1];
                        xy_next = t_reg[2];
                        yx_next = q_sat;
                        cnt_next = 5'd0;
                        state_next = ame_pkg::S_MUL;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 2'd1;
                        step_next = '0;
                        rem_next  = 64'd0;
                        quo_next  = 34'd0;
                        dvd_next  = {ln_mag, {(2 * FRAC_BITS){1'b0}}};
                        neg_next  = ln_neg ^ det_reg[63];
                    end
                end
            end

            ame_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    rx_next = 32'd0; ry_next = 32'd0;
                    oxn_next = 32'd0; oyn_next = 32'd0; oxx_next = 32'd0; oyx_next = 32'd0;
                    osing_next = sing_reg;
                    case (req_reg)
                        ame_pkg::REQ_IDENT:
                        begin
                            xx_next = ONE; yx_next = 32'd0; xy_next = 32'd0; yy_next = ONE;
                            ox_next = 32'd0; oy_next = 32'd0;
                        end
                        ame_pkg::REQ_LOAD:
                        begin
                            xx_next = mxx_reg; yx_next = myx_reg; xy_next = mxy_reg;
                            yy_next = myy_reg; ox_next = mox_reg; oy_next = moy_reg;
                        end
                        ame_pkg::REQ_CONCAT:
                        begin
                            xx_next = t_reg[0]; yx_next = t_reg[1]; xy_next = t_reg[2];
                            yy_next = t_reg[3]; ox_next = t_reg[4]; oy_next = t_reg[5];
                        end
                        ame_pkg::REQ_TRANS:
                        begin
                            ox_next = t_reg[0]; oy_next = t_reg[1];
                        end
                        ame_pkg::REQ_POINT:
                        begin
                            rx_next = t_reg[0]; ry_next = t_reg[1];
                        end
                        ame_pkg::REQ_RECT:
                        begin
                            oxn_next = bxn_reg; oyn_next = byn_reg;
                            oxx_next = bxx_reg; oyx_next = byx_reg;
                        end
                        ame_pkg::REQ_INVERT:
                        begin
                            if (sing_reg)
                            begin
                                xx_next = ONE; yx_next = 32'd0; xy_next = 32'd0;
                                yy_next = ONE; ox_next = 32'd0; oy_next = 32'd0;
                            end
                            else
                            begin
                                ox_next = t_reg[0]; oy_next = t_reg[1];
                            end
                        end
                        default: ;
                    endcase
                    state_next = ame_pkg::S_IDLE;
                end
            end

            default:
                state_next = ame_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ame_pkg::S_IDLE;
            cnt_reg       <= 5'd0;
            step_reg      <= '0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            xx_reg <= ONE; yx_reg <= 32'd0; xy_reg <= 32'd0; yy_reg <= ONE;
            ox_reg <= 32'd0; oy_reg <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            xx_reg <= xx_next; yx_reg <= yx_next; xy_reg <= xy_next; yy_reg <= yy_next;
            ox_reg <= ox_next; oy_reg <= oy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        mxx_reg <= mxx_next; myx_reg <= myx_next; mxy_reg <= mxy_next;
        myy_reg <= myy_next; mox_reg <= mox_next; moy_reg <= moy_next;
        x1_reg <= x1_next; y1_reg <= y1_next; x2_reg <= x2_next; y2_reg <= y2_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        for (int i = 0; i < 6; i++)
            t_reg[i] <= t_next[i];
        bxn_reg <= bxn_next; byn_reg <= byn_next; bxx_reg <= bxx_next; byx_reg <= byx_next;
        sing_reg <= sing_next;
        det_reg <= det_next; dvs_reg <= dvs_next; rem_reg <= rem_next;
        dvd_reg <= dvd_next; quo_reg <= quo_next; neg_reg <= neg_next;
        rx_reg <= rx_next; ry_reg <= ry_next;
        oxn_reg <= oxn_next; oyn_reg <= oyn_next; oxx_reg <= oxx_next; oyx_reg <= oyx_next;
        osing_reg <= osing_next;
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ame_pkg::S_DIV) |-> (dvs_reg != 64'd0))
        else $error("divider running with zero divisor");

    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ame_pkg::S_MUL) |-> (cnt_reg <= nprod))
        else $error("product counter past end of sequence");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ame_pkg::S_DONE))
        else $error("result raised outside completion");

    a_sing_invert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ame_pkg::S_DONE && sing_reg) |-> (req_reg == ame_pkg::REQ_INVERT))
        else $error("singular flag on a non-invert request");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: affine matrix engine testbench
// A directed table of requests covers each operation, the coefficient and
// point extremes, a singular invert and the unused request code. Random
// request streams follow. A local matrix model predicts each response that the
// table does not give, and each response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FB      = ame_pkg::FRAC_BITS_DEF;
    localparam int N_RAND  = 1530;
    localparam logic [2:0] REQ_BAD = 3'd7;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] m [6];
        logic signed [31:0] p [4];
    } cmd_t;

    typedef struct {
        logic signed [31:0] rx, ry, bx0, by0, bx1, by1;
        logic               sg;
    } resp_t;

    // directed row: request plus optional typed-in response
    typedef struct {
        cmd_t  c;
        logic  known;
        resp_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] req_type = '0;
    logic signed [31:0] in_xx = '0, in_yx = '0, in_xy = '0, in_yy = '0;
    logic signed [31:0] in_ox = '0, in_oy = '0;
    logic signed [31:0] pt_x1 = '0, pt_y1 = '0, pt_x2 = '0, pt_y2 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] res_x, res_y, box_x_min, box_y_min, box_x_max, box_y_max;
    logic singular;

    always #2 clk = ~clk;

    affine_matrix_engine_16_16 u_top (.*);

    // matrix model state
    logic signed [31:0] mxx, myx, mxy, myy, mox, moy;
    resp_t resp_q[$];
    int    errors = 0;
    bit    hold_off = 1'b0;

    function automatic logic signed [31:0] fmul(logic signed [31:0] a,
                                                logic signed [31:0] b);
        logic signed [63:0] pr;
        pr = 64'(a) * 64'(b);
        return 32'(pr >>> FB);
    endfunction

    function automatic logic signed [31:0] div_sat(logic signed [63:0] num,
                                                   logic signed [63:0] det);
        logic signed [127:0] q;
        q = (128'(num) <<< (2 * FB)) / 128'(det);
        if (q > 128'sd2147483647) return 32'h7fffffff;
        if (q < -128'sd2147483648) return 32'h80000000;
        return 32'(q);
    endfunction

    task automatic map_pt(input logic signed [31:0] x, y,
                          output logic signed [31:0] rx, ry);
        rx = fmul(mxx, x) + fmul(mxy, y) + mox;
        ry = fmul(myx, x) + fmul(myy, y) + moy;
    endtask

    task automatic set_ident();
        mxx = 32'sd1 <<< FB; myy = 32'sd1 <<< FB;
        myx = '0; mxy = '0; mox = '0; moy = '0;
    endtask

    function automatic resp_t zero_resp();
        resp_t r;
        r = '{0, 0, 0, 0, 0, 0, 1'b0};
        return r;
    endfunction

    task automatic apply_req(input cmd_t c, output resp_t r);
        logic signed [31:0] nxx, nyx, nxy, nyy, nox, noy, px, py;
        logic signed [31:0] cx [4];
        logic signed [31:0] cy [4];
        logic signed [63:0] det;
        r = zero_resp();
        case (c.op)
            ame_pkg::REQ_IDENT: set_ident();
            ame_pkg::REQ_LOAD: begin
                mxx = c.m[0]; myx = c.m[1]; mxy = c.m[2]; myy = c.m[3];
                mox = c.m[4]; moy = c.m[5];
            end
            ame_pkg::REQ_CONCAT: begin
                nxx = fmul(mxx, c.m[0]) + fmul(mxy, c.m[1]);
                nyx = fmul(myx, c.m[0]) + fmul(myy, c.m[1]);
                nxy = fmul(mxx, c.m[2]) + fmul(mxy, c.m[3]);
                nyy = fmul(myx, c.m[2]) + fmul(myy, c.m[3]);
                nox = fmul(mxx, c.m[4]) + fmul(mxy, c.m[5]) + mox;
                noy = fmul(myx, c.m[4]) + fmul(myy, c.m[5]) + moy;
                mxx = nxx; myx = nyx; mxy = nxy; myy = nyy; mox = nox; moy = noy;
            end
            ame_pkg::REQ_TRANS: begin
                mox = mox + fmul(mxx, c.p[0]) + fmul(mxy, c.p[1]);
                moy = moy + fmul(myx, c.p[0]) + fmul(myy, c.p[1]);
            end
            ame_pkg::REQ_POINT: map_pt(c.p[0], c.p[1], r.rx, r.ry);
            ame_pkg::REQ_RECT: begin
                cx = '{c.p[0], c.p[2], c.p[2], c.p[0]};
                cy = '{c.p[1], c.p[1], c.p[3], c.p[3]};
                for (int k = 0; k < 4; k++) begin
                    map_pt(cx[k], cy[k], px, py);
                    if (k == 0 || px < r.bx0) r.bx0 = px;
                    if (k == 0 || py < r.by0) r.by0 = py;
                    if (k == 0 || px > r.bx1) r.bx1 = px;
                    if (k == 0 || py > r.by1) r.by1 = py;
                end
            end
            ame_pkg::REQ_INVERT: begin
                det = 64'(mxx) * 64'(myy) - 64'(myx) * 64'(mxy);
                if (det == 0) begin
                    set_ident();
                    r.sg = 1'b1;
                end else begin
                    nxx = div_sat(64'(myy), det);
                    nyy = div_sat(64'(mxx), det);
                    nxy = div_sat(-64'(mxy), det);
                    nyx = div_sat(-64'(myx), det);
                    nox = -(fmul(mox, nxx) + fmul(moy, nxy));
                    noy = -(fmul(mox, nyx) + fmul(moy, nyy));
                    mxx = nxx; myx = nyx; mxy = nxy; myy = nyy; mox = nox; moy = noy;
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            3: return 32'(int'($urandom_range(0, 2000)) - 1000);
            4: return '0;
            default: return $urandom;
        endcase
    endfunction

    // mostly sane coefficients so long chains of transforms stay meaningful
    function automatic logic signed [31:0] rnd_coef();
        if ($urandom_range(0, 3) == 0) return rnd32();
        return 32'(int'($urandom_range(0, 262144)) - 131072);
    endfunction

    function automatic cmd_t rnd_cmd();
        cmd_t c;
        int w;
        w = $urandom_range(0, 99);
        if (w < 6) c.op = ame_pkg::REQ_IDENT;
        else if (w < 16) c.op = ame_pkg::REQ_LOAD;
        else if (w < 26) c.op = ame_pkg::REQ_CONCAT;
        else if (w < 36) c.op = ame_pkg::REQ_TRANS;
        else if (w < 66) c.op = ame_pkg::REQ_POINT;
        else if (w < 90) c.op = ame_pkg::REQ_RECT;
        else if (w < 98) c.op = ame_pkg::REQ_INVERT;
        else c.op = REQ_BAD;
        for (int i = 0; i < 4; i++) c.m[i] = rnd_coef();
        // occasionally make the matrix singular
        if ($urandom_range(0, 9) == 0) begin
            c.m[2] = '0;
            c.m[3] = '0;
        end
        c.m[4] = rnd32(); c.m[5] = rnd32();
        for (int i = 0; i < 4; i++) c.p[i] = rnd32();
        return c;
    endfunction

    function automatic cmd_t mk(logic [2:0] op, logic signed [31:0] a, b, cc, d,
                                logic signed [31:0] e, f, x1, y1, x2, y2);
        cmd_t c;
        c.op = op;
        c.m = '{a, b, cc, d, e, f};
        c.p = '{x1, y1, x2, y2};
        return c;
    endfunction

    function automatic resp_t rs(logic signed [31:0] rx, ry, bx0, by0, bx1, by1,
                                 logic sg);
        resp_t r;
        r = '{rx, ry, bx0, by0, bx1, by1, sg};
        return r;
    endfunction

    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam logic signed [31:0] MAXV = 32'h7fffffff;
    localparam logic signed [31:0] MINV = 32'h80000000;

    row_t rows[$];

    task automatic send(input cmd_t c);
        req_type <= c.op;
        in_xx <= c.m[0]; in_yx <= c.m[1]; in_xy <= c.m[2]; in_yy <= c.m[3];
        in_ox <= c.m[4]; in_oy <= c.m[5];
        pt_x1 <= c.p[0]; pt_y1 <= c.p[1]; pt_x2 <= c.p[2]; pt_y2 <= c.p[3];
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic issue(input row_t rw, input bit burst_end);
        resp_t r;
        apply_req(rw.c, r);
        if (rw.known && r != rw.r)
            $display("%0t table row disagrees with model for op %0d", $time, rw.c.op);
        resp_q.push_back(rw.known ? rw.r : r);
        send(rw.c);
        if (burst_end) drop_valid();
    endtask

    // stimulus
    initial begin
        row_t rw;
        int burst;
        set_ident();
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 5, -7, 0, 0), 1,
                         rs(5, -7, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, MAXV, MINV, 0, 0), 1,
                         rs(MAXV, MINV, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(ame_pkg::REQ_RECT, 0, 0, 0, 0, 0, 0, -3, -4, 10, 20), 1,
                         rs(0, 0, -3, -4, 10, 20, 0)});
        rows.push_back('{mk(ame_pkg::REQ_LOAD, 0, 0, 0, 0, 9, 9, 0, 0, 0, 0), 1,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         rs(0, 0, 0, 0, 0, 0, 1)});
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 1, 2, 0, 0), 1,
                         rs(1, 2, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(REQ_BAD, MAXV, MINV, -1, -1, MAXV, MINV, MAXV, MINV, -1, -1),
                         1, zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_LOAD, MAXV, MINV, MINV, MAXV, MAXV, MINV,
                            0, 0, 0, 0), 1, zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, MAXV, MINV, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_RECT, 0, 0, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV),
                         0, zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_LOAD, 2 * ONE, ONE / 2, -ONE, 3 * ONE, 100, -50,
                            0, 0, 0, 0), 1, zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_CONCAT, ONE, ONE, -ONE, ONE, 7, -3, 0, 0, 0, 0),
                         0, zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_TRANS, 0, 0, 0, 0, 0, 0, -1000, 2500, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 123, -456, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_RECT, 0, 0, 0, 0, 0, 0, 10, -20, -30, 40), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, 77, 88, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_LOAD, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0), 1,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_IDENT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         zero_resp()});
        rows.push_back('{mk(ame_pkg::REQ_POINT, 0, 0, 0, 0, 0, 0, -1, -1, 0, 0), 1,
                         rs(-1, -1, 0, 0, 0, 0, 0)});

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i]) issue(rows[i], $urandom_range(0, 2) == 0);

        burst = 0;
        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 3) begin
                // drain completely, then continue
                in_valid <= 1'b0;
                while (resp_q.size() != 0) @(negedge clk);
            end
            if (n == N_RAND / 2) hold_off = 1'b1;
            rw.c = rnd_cmd();
            rw.known = 1'b0;
            if (burst == 0) burst = $urandom_range(1, 20);
            burst--;
            issue(rw, burst == 0 && $urandom_range(0, 1));
        end
        in_valid <= 1'b0;
        while (resp_q.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver stall pattern with one long hold-off
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                hold_off = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // response checker
    always @(posedge clk) begin
        resp_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (resp_q.size() == 0) begin
                $display("%0t unexpected response", $time);
                errors++;
            end else begin
                e = resp_q.pop_front();
                if (res_x !== e.rx) begin
                    $display("%0t res_x exp %0d got %0d", $time, e.rx, res_x);
                    errors++;
                end
                if (res_y !== e.ry) begin
                    $display("%0t res_y exp %0d got %0d", $time, e.ry, res_y);
                    errors++;
                end
                if (box_x_min !== e.bx0) begin
                    $display("%0t box_x_min exp %0d got %0d", $time, e.bx0, box_x_min);
                    errors++;
                end
                if (box_y_min !== e.by0) begin
                    $display("%0t box_y_min exp %0d got %0d", $time, e.by0, box_y_min);
                    errors++;
                end
                if (box_x_max !== e.bx1) begin
                    $display("%0t box_x_max exp %0d got %0d", $time, e.bx1, box_x_max);
                    errors++;
                end
                if (box_y_max !== e.by1) begin
                    $display("%0t box_y_max exp %0d got %0d", $time, e.by1, box_y_max);
                    errors++;
                end
                if (singular !== e.sg) begin
                    $display("%0t singular exp %0b got %0b", $time, e.sg, singular);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ame_pkg.sv
rtl/affine_matrix_engine_16_16.sv
dv/tb_top.sv
